FILE: hw/rtl/sefpr_pkg.sv
// Shared widths, fixed-point constants, sine and Hann tables, and the
// command/status types for the sine excitation / FIR / peak-RMS block.
// Used by the controller, the datapath, the top level and the checker.
package sefpr_pkg;

    // Geometry
    localparam int TAPS         = 11;
    localparam int TABLE_POINTS = 200;
    localparam int HALF_POINTS  = TABLE_POINTS / 2;
    localparam int QTR_POINTS   = HALF_POINTS / 2;
    localparam int Q_ENTRIES    = QTR_POINTS + 1;
    localparam int QIDX_W       = $clog2(Q_ENTRIES);
    localparam int RUN_STEPS    = (TAPS > 4) ? TAPS : 4;
    localparam int TAP_W        = $clog2(TAPS);
    localparam int FILL_W       = $clog2(TAPS + 1);
    localparam int STEP_W       = $clog2(RUN_STEPS);

    // Field widths
    localparam int IDX_W    = 8;
    localparam int SAMPLE_W = 12;
    localparam int CODE_W   = 12;
    localparam int OUT_W    = 16;
    localparam int AMP_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDSCALE  = 1'b1;

    localparam logic [AMP_W-1:0]  AMP_RESET = 16'd0;
    localparam logic [CODE_W-1:0] MID_RESET = 12'd2047;

    // Sine path
    localparam int AMPC_W     = 15;
    localparam int MAG_W      = 18;
    localparam int P1_W       = 30;
    localparam int P2_W       = P1_W + MAG_W;
    localparam int FRAC_SHIFT = 30;
    localparam int X_W        = P2_W - FRAC_SHIFT;
    localparam int QUO_W      = 12;
    localparam int RECIP_W    = 19;
    localparam int RECIP_SH   = 25;
    localparam int HUND_W     = 7;

    localparam logic signed [AMP_W-1:0] AMP_LIMIT = 16'sd19660;
    localparam logic [AMPC_W-1:0] AMP_SUBST  = 15'd18022;
    localparam logic [15:0]       GAIN_Q15   = 16'd46334;
    // ceil(2^25 / 100): exact floor division by 100 for any 18-bit value
    localparam logic [RECIP_W-1:0] RECIP_100 = 19'd335545;
    localparam logic [HUND_W-1:0]  HUNDRED   = 7'd100;

    // FIR path
    localparam int COEF_W = 15;
    localparam int ACC_W  = 27;
    localparam int ACC_SH = 11;

    localparam logic [COEF_W-1:0] HANN [TAPS] = '{
        15'd0, 15'd619, 15'd2254, 15'd4286, 15'd5938, 15'd6567,
        15'd5938, 15'd4286, 15'd2254, 15'd619, 15'd0
    };

    // RMS
    localparam int RMSC_W = 15;
    localparam logic [RMSC_W-1:0] RMS_Q15 = 15'd23167;
    localparam int RMS_SH = 15;

    // Quarter sine wave in hundredths
    localparam logic [MAG_W-1:0] QUARTER_WAVE [Q_ENTRIES] = '{
        18'd0,      18'd6430,   18'd12853,  18'd19264,  18'd25656,
        18'd32022,  18'd38357,  18'd44654,  18'd50907,  18'd57109,
        18'd63256,  18'd69340,  18'd75355,  18'd81296,  18'd87157,
        18'd92932,  18'd98615,  18'd104201, 18'd109684, 18'd115058,
        18'd120320, 18'd125462, 18'd130481, 18'd135371, 18'd140127,
        18'd144745, 18'd149220, 18'd153548, 18'd157724, 18'd161745,
        18'd165606, 18'd169303, 18'd172834, 18'd176194, 18'd179380,
        18'd182389, 18'd185218, 18'd187864, 18'd190325, 18'd192598,
        18'd194681, 18'd196572, 18'd198269, 18'd199770, 18'd201074,
        18'd202180, 18'd203086, 18'd203792, 18'd204296, 18'd204599,
        18'd204700
    };

    // Magnitude of the sine table entry; zero outside the table
    function automatic logic [MAG_W-1:0] sine_mag(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] q;
        logic [IDX_W-1:0] m;
        q = (idx >= IDX_W'(HALF_POINTS)) ? idx - IDX_W'(HALF_POINTS) : idx;
        m = (q <= IDX_W'(QTR_POINTS)) ? q : IDX_W'(HALF_POINTS) - q;
        if (idx >= IDX_W'(TABLE_POINTS)) begin
            return '0;
        end else if (m >= IDX_W'(Q_ENTRIES)) begin
            return QUARTER_WAVE[Q_ENTRIES-1];
        end
        return QUARTER_WAVE[m[QIDX_W-1:0]];
    endfunction

    function automatic logic sine_neg(input logic [IDX_W-1:0] idx);
        return (idx >= IDX_W'(HALF_POINTS)) && (idx < IDX_W'(TABLE_POINTS));
    endfunction

    typedef struct packed {
        logic             load;
        logic             gain;
        logic             prod;
        logic             div;
        logic             fix;
        logic             mac;
        logic [TAP_W-1:0] tap;
        logic             fill;
        logic             fir_end;
        logic             peak;
        logic             rms;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic filling;
        logic last;
    } t_stat;

endpackage

FILE: hw/rtl/sine_excite_fir_peak_rms.sv
// Top level: sine DAC code generator with FIR-filtered ADC path and
// peak-to-peak RMS latch. Instantiates sefpr_ctrl and sefpr_dp; uses sefpr_pkg.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_stall      i_phase_index, i_adc_sample
//   output    out        o_out_valid / i_out_stall    o_dac_code, o_filtered_sample,
//                                                     o_rms_estimate, o_rms_valid
//   config    in         i_cfg_we (no handshake)      i_cfg_index, i_cfg_data
//
// From acceptance a word runs through an accept step, TAPS MAC steps (the sine
// multiply chain runs in the first four), then FIR close, peak, RMS and
// output load, which writes the result into the output register.
// The next word is accepted while the previous result waits in the output
// register; a stall on the output holds the sequencer in its last step.
// Synchronous active-low reset clears control, peaks, RMS and fill count.
module sine_excite_fir_peak_rms
    import sefpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [IDX_W-1:0]     i_phase_index,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CODE_W-1:0]    o_dac_code,
    output logic [OUT_W-1:0]     o_filtered_sample,
    output logic [OUT_W-1:0]     o_rms_estimate,
    output logic                 o_rms_valid
);

    t_cmd  cmd;
    t_stat stat;

    sefpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sefpr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_phase_index     (i_phase_index),
        .i_adc_sample      (i_adc_sample),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_dac_code        (o_dac_code),
        .o_filtered_sample (o_filtered_sample),
        .o_rms_estimate    (o_rms_estimate),
        .o_rms_valid       (o_rms_valid)
    );

endmodule

FILE: hw/rtl/sefpr_ctrl.sv
// Sequencer for one word: sine multiply chain alongside the FIR MAC
// loop, then peak, RMS and output load. Uses sefpr_pkg.
module sefpr_ctrl
    import sefpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_out_stall,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RUN  = 6'b000010,
        ST_FEND = 6'b000100,
        ST_PEAK = 6'b001000,
        ST_RMS  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    t_cmd              cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                // sine chain runs in the first four steps, MAC on every tap
                cmd.gain = (r_step == STEP_W'(0));
                cmd.prod = (r_step == STEP_W'(1));
                cmd.div  = (r_step == STEP_W'(2));
                cmd.fix  = (r_step == STEP_W'(3));
                cmd.mac  = ({1'b0, r_step} < (STEP_W + 1)'(TAPS));
                cmd.tap  = r_step[TAP_W-1:0];
                if (r_step == STEP_W'(RUN_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_FEND;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_FEND: begin
                cmd.fill    = i_stat.filling;
                cmd.fir_end = !i_stat.filling;
                n_state     = ST_PEAK;
            end
            ST_PEAK: begin
                cmd.peak = 1'b1;
                n_state  = ST_RMS;
            end
            ST_RMS: begin
                cmd.rms = i_stat.last;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/sefpr_dp.sv
// Datapath: config registers, sine offset chain, FIR window and MAC,
// peak tracking, RMS latch and output register. Uses sefpr_pkg.
module sefpr_dp
    import sefpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [IDX_W-1:0]     i_phase_index,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [CODE_W-1:0]    o_dac_code,
    output logic [OUT_W-1:0]     o_filtered_sample,
    output logic [OUT_W-1:0]     o_rms_estimate,
    output logic                 o_rms_valid
);

    logic signed [AMP_W-1:0]  r_amp;
    logic [CODE_W-1:0]        r_mid;
    logic [IDX_W-1:0]         r_idx;
    logic [SAMPLE_W-1:0]      r_sample;
    logic [P1_W-1:0]          r_p1;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [P2_W-1:0]          r_p2;
    logic [X_W-1:0]           r_x;
    logic [QUO_W-1:0]         r_q;
    logic                     r_low_nz;
    logic [CODE_W-1:0]        r_code;
    logic [ACC_W-1:0]         r_acc;
    logic [SAMPLE_W-1:0]      r_window [TAPS];
    logic [FILL_W-1:0]        r_fill;
    logic [OUT_W-1:0]         r_filt;
    logic [OUT_W-1:0]         r_high, r_low, r_rms;
    logic                     r_rms_flag;
    logic [CODE_W-1:0]        r_o_code;
    logic [OUT_W-1:0]         r_o_filt, r_o_rms;
    logic                     r_o_flag;

    logic [AMPC_W-1:0]           amp_c;
    logic [AMPC_W+15:0]          p1_full;
    logic [X_W+RECIP_W-1:0]      recip_prod;
    logic [QUO_W+HUND_W-1:0]     q_x100;
    logic                        rem_nz;
    logic [QUO_W:0]              off_mag;
    logic [OUT_W-1:0]            n_high, n_low;
    logic [OUT_W-1:0]            span;
    logic [OUT_W+RMSC_W-1:0]     rms_prod;

    // clamp: above the limit substitute, negative to zero
    always_comb begin
        if (r_amp > AMP_LIMIT) begin
            amp_c = AMP_SUBST;
        end else if (r_amp[AMP_W-1]) begin
            amp_c = '0;
        end else begin
            amp_c = r_amp[AMPC_W-1:0];
        end
    end

    assign p1_full    = amp_c * GAIN_Q15;
    assign recip_prod = r_p2[P2_W-1:FRAC_SHIFT] * RECIP_100;
    assign q_x100     = r_q * HUNDRED;
    // nonzero remainder turns the floor of a negative value one further down
    assign rem_nz     = ((QUO_W + HUND_W)'(r_x) != q_x100) || r_low_nz;
    assign off_mag    = {1'b0, r_q} + (QUO_W + 1)'(rem_nz);

    always_comb begin
        if (r_idx == '0) begin
            n_high = r_filt;
            n_low  = r_filt;
        end else begin
            n_high = (r_filt > r_high) ? r_filt : r_high;
            n_low  = (r_filt < r_low) ? r_filt : r_low;
        end
    end

    assign span     = (r_high >= r_low) ? r_high - r_low : '0;
    assign rms_prod = span * RMS_Q15;

    // config, fill count, peaks and RMS hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp  <= AMP_RESET;
            r_mid  <= MID_RESET;
            r_fill <= '0;
            r_high <= '0;
            r_low  <= '0;
            r_rms  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AMPLITUDE: r_amp <= i_cfg_data;
                    CFG_MIDSCALE:  r_mid <= i_cfg_data[CODE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.fill) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.peak) begin
                r_high <= n_high;
                r_low  <= n_low;
            end
            if (i_cmd.rms) begin
                r_rms <= rms_prod[RMS_SH +: OUT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx      <= i_phase_index;
            r_sample   <= i_adc_sample;
            r_acc      <= '0;
            r_rms_flag <= 1'b0;
        end
        if (i_cmd.gain) begin
            r_p1  <= p1_full[P1_W-1:0];
            r_mag <= sine_mag(r_idx);
            r_neg <= sine_neg(r_idx);
        end
        if (i_cmd.prod) begin
            r_p2 <= r_p1 * r_mag;
        end
        if (i_cmd.div) begin
            r_x      <= r_p2[P2_W-1:FRAC_SHIFT];
            r_low_nz <= |r_p2[FRAC_SHIFT-1:0];
            r_q      <= recip_prod[RECIP_SH +: QUO_W];
        end
        if (i_cmd.fix) begin
            if (r_neg) begin
                r_code <= r_mid - off_mag[CODE_W-1:0];
            end else begin
                r_code <= r_mid + r_q[CODE_W-1:0];
            end
        end
        if (i_cmd.mac) begin
            r_acc <= r_acc + HANN[i_cmd.tap] * r_window[TAP_W'(TAPS - 1) - i_cmd.tap];
        end
        if (i_cmd.fill) begin
            r_window[r_fill[TAP_W-1:0]] <= r_sample;
            r_filt                      <= {r_sample, 4'b0000};
        end
        if (i_cmd.fir_end) begin
            r_filt <= r_acc[ACC_SH +: OUT_W];
            // advance the window after the sum over the old one
            for (int i = 0; i < TAPS - 1; i++) begin
                r_window[i] <= r_window[i+1];
            end
            r_window[TAPS-1] <= r_sample;
        end
        if (i_cmd.rms) begin
            r_rms_flag <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_code <= r_code;
            r_o_filt <= r_filt;
            r_o_rms  <= r_rms;
            r_o_flag <= r_rms_flag;
        end
    end

    assign o_stat.filling    = (r_fill < FILL_W'(TAPS));
    assign o_stat.last       = (r_idx == IDX_W'(TABLE_POINTS - 1));
    assign o_dac_code        = r_o_code;
    assign o_filtered_sample = r_o_filt;
    assign o_rms_estimate    = r_o_rms;
    assign o_rms_valid       = r_o_flag;

endmodule

FILE: hw/rtl/sefpr_chk.sv
// Port-level checker for sine_excite_fir_peak_rms, attached by bind.
// Uses sefpr_pkg for field widths.
module sefpr_chk
    import sefpr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CODE_W-1:0] o_dac_code,
    input logic [OUT_W-1:0]  o_filtered_sample,
    input logic [OUT_W-1:0]  o_rms_estimate,
    input logic              o_rms_valid
);

    // reset leaves the block ready and the output empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // an accepted word keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    // a new output word only appears as the sequencer returns to idle
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall) && !o_in_stall)
        else $error("output word without a finished sequence");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dac_code)
            && $stable(o_filtered_sample) && $stable(o_rms_estimate)
            && $stable(o_rms_valid))
        else $error("stalled output word changed");

endmodule

bind sine_excite_fir_peak_rms sefpr_chk u_sefpr_chk (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for sine_excite_fir_peak_rms: random and directed words checked against
// an independent predictor of the DAC code, FIR output and peak-to-peak RMS.
// Depends on sefpr_pkg for port widths and register indexes.
module testbench;
    import sefpr_pkg::*;

    localparam int     FIR_LEN         = 11;
    localparam int     SINE_POINTS     = 200;
    localparam longint AMP_CLAMP_AT    = 19660;
    localparam longint AMP_CLAMP_TO    = 18022;
    localparam longint DAC_GAIN        = 46334;
    localparam longint SINE_DIV        = 64'sd107374182400;
    localparam int     RMS_GAIN        = 23167;
    localparam int     ACC_SHIFT       = 11;
    localparam int     PHASES          = 8;
    localparam int     PHASE_WORDS     = 60;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     TAIL_CYCLES     = 40;
    localparam int     WATCHDOG_LIMIT  = 3000;
    localparam int     MAX_REPORTS     = 200;

    localparam int SINE_QUARTER [51] = '{
        0, 6430, 12853, 19264, 25656, 32022, 38357, 44654, 50907, 57109,
        63256, 69340, 75355, 81296, 87157, 92932, 98615, 104201, 109684, 115058,
        120320, 125462, 130481, 135371, 140127, 144745, 149220, 153548, 157724, 161745,
        165606, 169303, 172834, 176194, 179380, 182389, 185218, 187864, 190325, 192598,
        194681, 196572, 198269, 199770, 201074, 202180, 203086, 203792, 204296, 204599,
        204700
    };

    localparam int HANN_Q15 [FIR_LEN] = '{
        0, 619, 2254, 4286, 5938, 6567, 5938, 4286, 2254, 619, 0
    };

    typedef struct packed {
        logic [CODE_W-1:0] dac_code;
        logic [OUT_W-1:0]  filtered;
        logic [OUT_W-1:0]  rms;
        logic              rms_valid;
    } t_exc_word;

    class sine_fir_scoreboard;
        logic signed [15:0] amplitude;
        logic [11:0]        midscale;
        logic [11:0]        window [FIR_LEN];
        int                 fill_count;
        logic [15:0]        peak_high;
        logic [15:0]        peak_low;
        logic [15:0]        rms_hold;
        t_exc_word          expected_words [$];
        int                 errors;

        function new();
            amplitude  = 16'sd0;
            midscale   = 12'd2047;
            foreach (window[i]) window[i] = '0;
            fill_count = 0;
            peak_high  = '0;
            peak_low   = '0;
            rms_hold   = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_AMPLITUDE: amplitude = data;
                CFG_MIDSCALE:  midscale  = data[11:0];
                default: ;
            endcase
        endfunction

        // Signed table value in hundredths; zero past the end of the table
        function longint sine_value(int idx);
            int q;
            int m;
            if (idx >= SINE_POINTS) return 0;
            q = (idx >= SINE_POINTS / 2) ? idx - SINE_POINTS / 2 : idx;
            m = (q <= SINE_POINTS / 4) ? q : SINE_POINTS / 2 - q;
            return (idx >= SINE_POINTS / 2) ? -SINE_QUARTER[m] : SINE_QUARTER[m];
        endfunction

        function void note_input(logic [IDX_W-1:0] phase, logic [SAMPLE_W-1:0] sample);
            longint    amp;
            longint    tab;
            longint    mag;
            longint    quo;
            int        acc;
            int        span;
            int        i;
            t_exc_word w;
            amp = amplitude;
            if (amp > AMP_CLAMP_AT) amp = AMP_CLAMP_TO;
            if (amp < 0) amp = 0;
            tab = sine_value(phase);
            mag = amp * DAC_GAIN * ((tab < 0) ? -tab : tab);
            quo = mag / SINE_DIV;
            // round toward minus infinity on the negative half
            if (tab < 0) begin
                if (mag % SINE_DIV != 0) quo = quo + 1;
                quo = -quo;
            end
            w.dac_code = midscale + quo[11:0];

            if (fill_count < FIR_LEN) begin
                window[fill_count] = sample;
                fill_count++;
                w.filtered = {sample, 4'b0000};
            end else begin
                acc = 0;
                for (i = 0; i < FIR_LEN; i++) begin
                    acc += HANN_Q15[i] * int'(window[FIR_LEN-1-i]);
                end
                w.filtered = 16'(acc >> ACC_SHIFT);
                for (i = 0; i < FIR_LEN - 1; i++) begin
                    window[i] = window[i+1];
                end
                window[FIR_LEN-1] = sample;
            end

            w.rms_valid = 1'b0;
            if (phase == 0) begin
                peak_high = w.filtered;
                peak_low  = w.filtered;
            end else begin
                if (w.filtered > peak_high) peak_high = w.filtered;
                if (w.filtered < peak_low) peak_low = w.filtered;
                if (phase == SINE_POINTS - 1) begin
                    span = (peak_high >= peak_low) ? int'(peak_high) - int'(peak_low) : 0;
                    rms_hold = 16'((span * RMS_GAIN) >> 15);
                    w.rms_valid = 1'b1;
                end
            end
            w.rms = rms_hold;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                end
                errors++;
            end
        endfunction

        function void check_result(t_exc_word got);
            t_exc_word want;
            if (expected_words.size() == 0) begin
                $display("%0t: output word with none expected, code %0d filtered %0d rms %0d",
                         $time, got.dac_code, got.filtered, got.rms);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("dac_code", want.dac_code, got.dac_code);
            compare_field("filtered_sample", want.filtered, got.filtered);
            compare_field("rms_estimate", want.rms, got.rms);
            compare_field("rms_valid", want.rms_valid, got.rms_valid);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [IDX_W-1:0]     i_phase_index = '0;
    logic [SAMPLE_W-1:0]  i_adc_sample = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CODE_W-1:0]    o_dac_code;
    logic [OUT_W-1:0]     o_filtered_sample;
    logic [OUT_W-1:0]     o_rms_estimate;
    logic                 o_rms_valid;

    sine_fir_scoreboard sb = new();
    bit                 hold_off_req = 1'b0;
    int                 idle_cycles = 0;
    logic [IDX_W-1:0]   sweep_pos = 8'd199;

    sine_excite_fir_peak_rms uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_phase_index     (i_phase_index),
        .i_adc_sample      (i_adc_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_dac_code        (o_dac_code),
        .o_filtered_sample (o_filtered_sample),
        .o_rms_estimate    (o_rms_estimate),
        .o_rms_valid       (o_rms_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_dac_code, o_filtered_sample, o_rms_estimate, o_rms_valid});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall runs, plus one long hold-off once the random part starts
    initial begin : out_stall_pattern
        int run_len;
        int stall_pct;
        int k;
        bit held;
        held = 1'b0;
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                for (k = 0; k < HOLD_OFF_CYCLES; k++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                run_len = $urandom_range(8, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
                for (k = 0; k < run_len; k++) begin
                    i_out_stall <= ($urandom_range(0, 99) < stall_pct);
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_word(input logic [IDX_W-1:0] phase, input logic [SAMPLE_W-1:0] sample);
        i_in_valid    <= 1'b1;
        i_phase_index <= phase;
        i_adc_sample  <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(phase, sample);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] amp, input logic [CFG_W-1:0] mid);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_AMPLITUDE;
        i_cfg_data  <= amp;
        @(posedge i_clk);
        sb.write_register(CFG_AMPLITUDE, amp);
        i_cfg_index <= CFG_MIDSCALE;
        i_cfg_data  <= mid;
        @(posedge i_clk);
        sb.write_register(CFG_MIDSCALE, mid);
        i_cfg_we <= 1'b0;
    endtask

    // Sweep toward the end of the table, always land on its last entry, then restart at zero
    function automatic logic [IDX_W-1:0] next_phase(input logic [IDX_W-1:0] cur);
        int step;
        if (cur >= SINE_POINTS - 1) return '0;
        step = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 20);
        return (cur + step > SINE_POINTS - 1) ? IDX_W'(SINE_POINTS - 1) : IDX_W'(cur + step);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    initial begin : stimulus
        int p;
        int n;
        int gap;
        int burst_left;
        logic [CFG_W-1:0] amp;
        logic [CFG_W-1:0] mid;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: latch before any restart, out-of-table indexes
        send_word(8'd199, 12'd4095);
        send_word(8'd255, 12'd0);
        send_word(8'd0, 12'd4095);
        send_word(8'd200, 12'd2048);
        wait_drained();
        // Amplitude clamped from full scale, midscale at top: code wraps past 4095
        load_settings(16'h7FFF, 16'hFFFF);
        send_word(8'd50, 12'd0);
        send_word(8'd150, 12'd4095);
        send_word(8'd25, 12'd1);
        send_word(8'd0, 12'd2730);
        send_word(8'd75, 12'd1365);
        send_word(8'd199, 12'd0);
        wait_drained();
        // Negative amplitude forces zero offset; window fills here
        load_settings(16'h8000, 16'h0000);
        send_word(8'd50, 12'd4095);
        send_word(8'd200, 12'd0);
        wait_drained();
        // Largest unclamped amplitude, low midscale: code wraps below zero
        load_settings(16'd19660, 16'hF064);
        send_word(8'd150, 12'd4095);
        send_word(8'd50, 12'd0);
        send_word(8'd199, 12'd4095);
        wait_drained();
        load_settings(16'd19661, 16'h0A5A);
        send_word(8'd50, 12'd2048);
        send_word(8'd125, 12'd0);
        send_word(8'd0, 12'd4095);
        send_word(8'd199, 12'd1);

        burst_left = 0;
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: amp = 16'h7FFF;
                1: amp = 16'h8000;
                2: amp = 16'd19660;
                3: amp = 16'd19661;
                4: amp = 16'hFFFF;
                5: amp = 16'h0000;
                6: amp = CFG_W'($urandom_range(0, 65535));
                default: amp = CFG_W'($urandom_range(0, 19660));
            endcase
            case (p % 3)
                0: mid = CFG_W'($urandom_range(0, 65535));
                1: mid = 16'h0000;
                default: mid = 16'hFFFF;
            endcase
            load_settings(amp, mid);
            // start the long receiver hold-off while words keep coming
            if (p == 0) hold_off_req = 1'b1;
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 9) == 0) begin
                    // stray index, sweep position untouched
                    send_word(IDX_W'($urandom_range(0, 255)), random_sample());
                end else begin
                    sweep_pos = next_phase(sweep_pos);
                    send_word(sweep_pos, random_sample());
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sine_excite_fir_peak_rms.f
hw/rtl/sefpr_pkg.sv
hw/rtl/sefpr_ctrl.sv
hw/rtl/sefpr_dp.sv
hw/rtl/sine_excite_fir_peak_rms.sv
hw/rtl/sefpr_chk.sv
sim/testbench.sv
